// File: rtl/amp_residual_and_variance_macros.svh
// Assertion helpers used by amp_ctrl.sv; clk and rst must be in scope.
`ifndef AMP_RESIDUAL_AND_VARIANCE_MACROS_SVH
`define AMP_RESIDUAL_AND_VARIANCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ARV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/amp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package amp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_WIDTH = 64;
  localparam int HALF_W    = (ACC_WIDTH + 1) / 2;
  localparam int PROD_W    = 2 * ACC_WIDTH;
  localparam int DIVD_W    = ACC_WIDTH + FRAC_BITS;
  localparam int DIVR_W    = 31;
  localparam int MEM_AW    = 4;
  localparam int MEM_DEPTH = 1 << MEM_AW;
  localparam int PC_W      = 7;

  typedef logic signed [ACC_WIDTH-1:0] acc_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    K_MUL, K_ADD, K_SUB, K_DIV, K_BZ, K_OUTZ, K_OUT, K_END
  } kind_t;

  // operand / destination codes: below 16 are scratch store entries
  localparam logic [4:0] SRC_ZS   = 5'd0;
  localparam logic [4:0] SRC_ARE  = 5'd1;
  localparam logic [4:0] SRC_AIM  = 5'd2;
  localparam logic [4:0] SRC_BRE  = 5'd3;
  localparam logic [4:0] SRC_BIM  = 5'd4;
  localparam logic [4:0] SRC_CRE  = 5'd5;
  localparam logic [4:0] SRC_CIM  = 5'd6;
  localparam logic [4:0] SRC_T0   = 5'd7;
  localparam logic [4:0] SRC_T1   = 5'd8;
  localparam logic [4:0] SRC_T2   = 5'd9;
  localparam logic [4:0] SRC_T3   = 5'd10;
  localparam logic [4:0] SRC_T4   = 5'd11;
  localparam logic [4:0] SRC_T5   = 5'd12;
  localparam logic [4:0] SRC_T6   = 5'd13;
  localparam logic [4:0] SRC_HRE  = 5'd16;
  localparam logic [4:0] SRC_HIM  = 5'd17;
  localparam logic [4:0] SRC_VH   = 5'd18;
  localparam logic [4:0] SRC_XRE  = 5'd19;
  localparam logic [4:0] SRC_XIM  = 5'd20;
  localparam logic [4:0] SRC_VX   = 5'd21;
  localparam logic [4:0] SRC_XPRE = 5'd22;
  localparam logic [4:0] SRC_XPIM = 5'd23;
  localparam logic [4:0] SRC_HPRE = 5'd24;
  localparam logic [4:0] SRC_HPIM = 5'd25;
  localparam logic [4:0] SRC_NV   = 5'd26;
  localparam logic [4:0] SRC_ZERO = 5'd27;

  localparam logic [PC_W-1:0] FIN_PC  = 7'd40;
  localparam logic [PC_W-1:0] VX_PC   = 7'd54;
  localparam logic [PC_W-1:0] OUT_PC  = 7'd65;
  localparam logic [PC_W-1:0] LAST_PC = 7'd66;

  typedef struct packed {
    kind_t           kind;
    logic [4:0]      dst;
    logic [4:0]      a;
    logic [4:0]      b;
    logic [PC_W-1:0] tgt;
  } instr_t;

  typedef struct packed {
    instr_t ins;
    logic   load;
    logic   rd_en;
    logic   alu_wr;
    logic   mul_start;
    logic   div_start;
    logic   set_zdiv;
    logic   latch_zeta;
    logic   emit;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic opb_zero;
    logic out_free;
  } sts_t;

  function automatic instr_t mk(kind_t k, logic [4:0] d, logic [4:0] a, logic [4:0] b,
                                logic [PC_W-1:0] t);
    instr_t i;
    i.kind = k;
    i.dst  = d;
    i.a    = a;
    i.b    = b;
    i.tgt  = t;
    return i;
  endfunction

  function automatic logic [ACC_WIDTH-1:0] mag(acc_t v);
    return v[ACC_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // Micro-program: element update from 0, finish from FIN_PC.
  function automatic instr_t prog(logic [PC_W-1:0] pc);
    instr_t i;
    unique case (pc)
      // zeta term
      7'd0:  i = mk(K_MUL, SRC_T0, SRC_XRE, SRC_XRE, '0);
      7'd1:  i = mk(K_MUL, SRC_T1, SRC_XIM, SRC_XIM, '0);
      7'd2:  i = mk(K_ADD, SRC_T0, SRC_T0, SRC_T1, '0);
      7'd3:  i = mk(K_ADD, SRC_T1, SRC_VX, SRC_T0, '0);
      7'd4:  i = mk(K_MUL, SRC_T1, SRC_VH, SRC_T1, '0);
      7'd5:  i = mk(K_MUL, SRC_T2, SRC_HRE, SRC_HRE, '0);
      7'd6:  i = mk(K_MUL, SRC_T3, SRC_HIM, SRC_HIM, '0);
      7'd7:  i = mk(K_ADD, SRC_T2, SRC_T2, SRC_T3, '0);
      7'd8:  i = mk(K_MUL, SRC_T2, SRC_T2, SRC_VX, '0);
      7'd9:  i = mk(K_ADD, SRC_T1, SRC_T1, SRC_T2, '0);
      7'd10: i = mk(K_ADD, SRC_ZS, SRC_ZS, SRC_T1, '0);
      // a += h*x
      7'd11: i = mk(K_MUL, SRC_T0, SRC_HRE, SRC_XRE, '0);
      7'd12: i = mk(K_MUL, SRC_T1, SRC_HIM, SRC_XIM, '0);
      7'd13: i = mk(K_SUB, SRC_T0, SRC_T0, SRC_T1, '0);
      7'd14: i = mk(K_ADD, SRC_ARE, SRC_ARE, SRC_T0, '0);
      7'd15: i = mk(K_MUL, SRC_T0, SRC_HRE, SRC_XIM, '0);
      7'd16: i = mk(K_MUL, SRC_T1, SRC_HIM, SRC_XRE, '0);
      7'd17: i = mk(K_ADD, SRC_T0, SRC_T0, SRC_T1, '0);
      7'd18: i = mk(K_ADD, SRC_AIM, SRC_AIM, SRC_T0, '0);
      // b += vh*conj(xp)*x
      7'd19: i = mk(K_MUL, SRC_T0, SRC_XPRE, SRC_XRE, '0);
      7'd20: i = mk(K_MUL, SRC_T1, SRC_XPIM, SRC_XIM, '0);
      7'd21: i = mk(K_ADD, SRC_T0, SRC_T0, SRC_T1, '0);
      7'd22: i = mk(K_MUL, SRC_T0, SRC_VH, SRC_T0, '0);
      7'd23: i = mk(K_ADD, SRC_BRE, SRC_BRE, SRC_T0, '0);
      7'd24: i = mk(K_MUL, SRC_T0, SRC_XPRE, SRC_XIM, '0);
      7'd25: i = mk(K_MUL, SRC_T1, SRC_XPIM, SRC_XRE, '0);
      7'd26: i = mk(K_SUB, SRC_T0, SRC_T0, SRC_T1, '0);
      7'd27: i = mk(K_MUL, SRC_T0, SRC_VH, SRC_T0, '0);
      7'd28: i = mk(K_ADD, SRC_BIM, SRC_BIM, SRC_T0, '0);
      // c += vx*conj(hp)*h
      7'd29: i = mk(K_MUL, SRC_T0, SRC_HPRE, SRC_HRE, '0);
      7'd30: i = mk(K_MUL, SRC_T1, SRC_HPIM, SRC_HIM, '0);
      7'd31: i = mk(K_ADD, SRC_T0, SRC_T0, SRC_T1, '0);
      7'd32: i = mk(K_MUL, SRC_T0, SRC_VX, SRC_T0, '0);
      7'd33: i = mk(K_ADD, SRC_CRE, SRC_CRE, SRC_T0, '0);
      7'd34: i = mk(K_MUL, SRC_T0, SRC_HPRE, SRC_HIM, '0);
      7'd35: i = mk(K_MUL, SRC_T1, SRC_HPIM, SRC_HRE, '0);
      7'd36: i = mk(K_SUB, SRC_T0, SRC_T0, SRC_T1, '0);
      7'd37: i = mk(K_MUL, SRC_T0, SRC_VX, SRC_T0, '0);
      7'd38: i = mk(K_ADD, SRC_CIM, SRC_CIM, SRC_T0, '0);
      7'd39: i = mk(K_END, SRC_ZERO, SRC_ZERO, SRC_ZERO, '0);
      // finish
      7'd40: i = mk(K_ADD, SRC_T4, SRC_NV, SRC_ZS, '0);
      7'd41: i = mk(K_SUB, SRC_T5, SRC_HRE, SRC_ARE, '0);
      7'd42: i = mk(K_SUB, SRC_T6, SRC_HIM, SRC_AIM, '0);
      7'd43: i = mk(K_BZ, SRC_ZERO, SRC_ZERO, SRC_VH, VX_PC);
      7'd44: i = mk(K_MUL, SRC_T0, SRC_BRE, SRC_XRE, '0);
      7'd45: i = mk(K_MUL, SRC_T1, SRC_BIM, SRC_XIM, '0);
      7'd46: i = mk(K_SUB, SRC_T0, SRC_T0, SRC_T1, '0);
      7'd47: i = mk(K_DIV, SRC_T0, SRC_T0, SRC_VH, '0);
      7'd48: i = mk(K_ADD, SRC_T5, SRC_T5, SRC_T0, '0);
      7'd49: i = mk(K_MUL, SRC_T0, SRC_BRE, SRC_XIM, '0);
      7'd50: i = mk(K_MUL, SRC_T1, SRC_BIM, SRC_XRE, '0);
      7'd51: i = mk(K_ADD, SRC_T0, SRC_T0, SRC_T1, '0);
      7'd52: i = mk(K_DIV, SRC_T0, SRC_T0, SRC_VH, '0);
      7'd53: i = mk(K_ADD, SRC_T6, SRC_T6, SRC_T0, '0);
      7'd54: i = mk(K_BZ, SRC_ZERO, SRC_ZERO, SRC_VX, OUT_PC);
      7'd55: i = mk(K_MUL, SRC_T0, SRC_CRE, SRC_XPRE, '0);
      7'd56: i = mk(K_MUL, SRC_T1, SRC_CIM, SRC_XPIM, '0);
      7'd57: i = mk(K_SUB, SRC_T0, SRC_T0, SRC_T1, '0);
      7'd58: i = mk(K_DIV, SRC_T0, SRC_T0, SRC_VX, '0);
      7'd59: i = mk(K_ADD, SRC_T5, SRC_T5, SRC_T0, '0);
      7'd60: i = mk(K_MUL, SRC_T0, SRC_CRE, SRC_XPIM, '0);
      7'd61: i = mk(K_MUL, SRC_T1, SRC_CIM, SRC_XPRE, '0);
      7'd62: i = mk(K_ADD, SRC_T0, SRC_T0, SRC_T1, '0);
      7'd63: i = mk(K_DIV, SRC_T0, SRC_T0, SRC_VX, '0);
      7'd64: i = mk(K_ADD, SRC_T6, SRC_T6, SRC_T0, '0);
      7'd65: i = mk(K_OUTZ, SRC_ZERO, SRC_T4, SRC_ZERO, '0);
      7'd66: i = mk(K_OUT, SRC_ZERO, SRC_T5, SRC_T6, '0);
      default: i = mk(K_END, SRC_ZERO, SRC_ZERO, SRC_ZERO, '0);
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

// File: rtl/amp_qmul.sv
`timescale 1ns / 1ps
`default_nettype none
// Fixed-point multiply: four half-width partial products, then round and clip.
module amp_qmul
  import amp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire acc_t a,
  input  wire acc_t b,
  output logic      done,
  output acc_t      result,
  output logic      sat
);

  logic [ACC_WIDTH-1:0] ma, mb;
  logic                 neg;
  logic [PROD_W-1:0]    prod;
  logic [2:0]           cnt;
  logic                 busy;

  logic [HALF_W-1:0]   sa, sb;
  logic [2*HALF_W-1:0] pp;
  logic [PROD_W-1:0]   ppx;
  logic [1:0]          sh;
  logic [PROD_W-1:0]   rnd, q, lim;
  logic                ovf;
  logic [ACC_WIDTH-1:0] m;

  always_comb begin
    sa  = cnt[1] ? HALF_W'(ma >> HALF_W) : ma[HALF_W-1:0];
    sb  = cnt[0] ? HALF_W'(mb >> HALF_W) : mb[HALF_W-1:0];
    pp  = (2*HALF_W)'(sa) * (2*HALF_W)'(sb);
    sh  = {1'b0, cnt[1]} + {1'b0, cnt[0]};
    unique case (sh)
      2'd0:    ppx = PROD_W'(pp);
      2'd1:    ppx = PROD_W'(pp) << HALF_W;
      default: ppx = PROD_W'(pp) << (2 * HALF_W);
    endcase
    rnd = prod + (PROD_W'(1) << (FRAC_BITS - 1));
    q   = rnd >> FRAC_BITS;
    lim = (PROD_W'(1) << (ACC_WIDTH - 1)) - PROD_W'(!neg);
    ovf = q > lim;
    m   = ovf ? lim[ACC_WIDTH-1:0] : q[ACC_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt[2]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= mag(a);
      mb   <= mag(b);
      neg  <= a[ACC_WIDTH-1] ^ b[ACC_WIDTH-1];
      prod <= '0;
    end else if (busy && !cnt[2]) begin
      prod <= prod + ppx;
    end
    if (busy && cnt[2]) begin
      result <= neg ? acc_t'(~m + 1'b1) : acc_t'(m);
      sat    <= ovf;
    end
  end

endmodule
`default_nettype wire

// File: rtl/amp_qdiv.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divide, one quotient bit a cycle, rounded half away from zero.
module amp_qdiv
  import amp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire acc_t              num,
  input  wire logic [DIVR_W-1:0] den,
  output logic                   done,
  output acc_t                   result,
  output logic                   sat
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] dvd;
  logic [DIVR_W-1:0] rem, d_r;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic [DIVR_W:0]   t;
  logic              ge;
  logic              rup;
  logic [DIVD_W:0]   q1, lim;
  logic              ovf;
  logic [ACC_WIDTH-1:0] m;

  always_comb begin
    t   = {rem, dvd[DIVD_W-1]};
    ge  = t >= {1'b0, d_r};
    rup = {rem, 1'b0} >= {1'b0, d_r};
    q1  = {1'b0, dvd} + (DIVD_W+1)'(rup);
    lim = ((DIVD_W+1)'(1) << (ACC_WIDTH - 1)) - (DIVD_W+1)'(!neg);
    ovf = q1 > lim;
    m   = ovf ? lim[ACC_WIDTH-1:0] : q1[ACC_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVD_W);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {mag(num), {FRAC_BITS{1'b0}}};
      rem <= '0;
      d_r <= den;
      neg <= num[ACC_WIDTH-1];
    end else if (busy && cnt != '0) begin
      rem <= ge ? DIVR_W'(t - {1'b0, d_r}) : t[DIVR_W-1:0];
      dvd <= {dvd[DIVD_W-2:0], ge};
    end
    if (busy && cnt == '0) begin
      result <= neg ? acc_t'(~m + 1'b1) : acc_t'(m);
      sat    <= ovf;
    end
  end

endmodule
`default_nettype wire

// File: rtl/amp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module amp_dp
  import amp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic              cfg_we,
  input  wire logic [30:0]       cfg_data,
  input  wire logic signed [31:0] h_re,
  input  wire logic signed [31:0] h_im,
  input  wire logic [30:0]       vh,
  input  wire logic signed [31:0] x_re,
  input  wire logic signed [31:0] x_im,
  input  wire logic [30:0]       vx,
  input  wire logic signed [31:0] xp_re,
  input  wire logic signed [31:0] xp_im,
  input  wire logic signed [31:0] hp_re,
  input  wire logic signed [31:0] hp_im,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            zeta_out,
  output logic signed [31:0]     z_re,
  output logic signed [31:0]     z_im,
  output logic                   saturated,
  output logic                   zero_divisor
);

  logic [30:0] noise_variance;
  acc_t hre_r, him_r, vh_r, xre_r, xim_r, vx_r, xpre_r, xpim_r, hpre_r, hpim_r;

  acc_t                 mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld;
  acc_t                 rd_a, rd_b;
  acc_t                 opa, opb;

  logic [ACC_WIDTH:0] sum;
  logic               alu_ovf;
  acc_t               alu_res;

  logic mul_done, mul_sat, div_done, div_sat;
  acc_t mul_res, div_res;

  logic        wr_en;
  acc_t        wr_data;
  logic        sticky, zdiv;
  logic [31:0] zeta_hold;
  logic        zeta_clip, zr_clip, zi_clip;
  logic [31:0] zeta_c, zr_c, zi_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_variance <= 31'd65536;
    end else if (cfg_we) begin
      noise_variance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hre_r  <= acc_t'(h_re);
      him_r  <= acc_t'(h_im);
      vh_r   <= acc_t'(vh);
      xre_r  <= acc_t'(x_re);
      xim_r  <= acc_t'(x_im);
      vx_r   <= acc_t'(vx);
      xpre_r <= acc_t'(xp_re);
      xpim_r <= acc_t'(xp_im);
      hpre_r <= acc_t'(hp_re);
      hpim_r <= acc_t'(hp_im);
    end
  end

  always_comb begin
    unique case (cmd.ins.a)
      SRC_HRE:  opa = hre_r;
      SRC_HIM:  opa = him_r;
      SRC_VH:   opa = vh_r;
      SRC_XRE:  opa = xre_r;
      SRC_XIM:  opa = xim_r;
      SRC_VX:   opa = vx_r;
      SRC_XPRE: opa = xpre_r;
      SRC_XPIM: opa = xpim_r;
      SRC_HPRE: opa = hpre_r;
      SRC_HPIM: opa = hpim_r;
      SRC_NV:   opa = acc_t'(noise_variance);
      SRC_ZERO: opa = '0;
      default:  opa = rd_a;
    endcase
    unique case (cmd.ins.b)
      SRC_HRE:  opb = hre_r;
      SRC_HIM:  opb = him_r;
      SRC_VH:   opb = vh_r;
      SRC_XRE:  opb = xre_r;
      SRC_XIM:  opb = xim_r;
      SRC_VX:   opb = vx_r;
      SRC_XPRE: opb = xpre_r;
      SRC_XPIM: opb = xpim_r;
      SRC_HPRE: opb = hpre_r;
      SRC_HPIM: opb = hpim_r;
      SRC_NV:   opb = acc_t'(noise_variance);
      SRC_ZERO: opb = '0;
      default:  opb = rd_b;
    endcase
  end

  // saturating add / subtract
  always_comb begin
    if (cmd.ins.kind == K_SUB) begin
      sum = {opa[ACC_WIDTH-1], opa} - {opb[ACC_WIDTH-1], opb};
    end else begin
      sum = {opa[ACC_WIDTH-1], opa} + {opb[ACC_WIDTH-1], opb};
    end
    alu_ovf = sum[ACC_WIDTH] ^ sum[ACC_WIDTH-1];
    if (alu_ovf) begin
      alu_res = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      alu_res = sum[ACC_WIDTH-1:0];
    end
  end

  amp_qmul u_qmul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (opa),
    .b      (opb),
    .done   (mul_done),
    .result (mul_res),
    .sat    (mul_sat)
  );

  amp_qdiv u_qdiv (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .num    (opa),
    .den    (opb[DIVR_W-1:0]),
    .done   (div_done),
    .result (div_res),
    .sat    (div_sat)
  );

  always_comb begin
    wr_en = cmd.alu_wr | mul_done | div_done;
    priority if (mul_done) begin
      wr_data = mul_res;
    end else if (div_done) begin
      wr_data = div_res;
    end else begin
      wr_data = alu_res;
    end
  end

  // scratch store; entries not written since the last finish read as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cmd.ins.dst[MEM_AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a <= vld[cmd.ins.a[MEM_AW-1:0]] ? mem[cmd.ins.a[MEM_AW-1:0]] : '0;
      rd_b <= vld[cmd.ins.b[MEM_AW-1:0]] ? mem[cmd.ins.b[MEM_AW-1:0]] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[cmd.ins.dst[MEM_AW-1:0]] <= 1'b1;
    end
  end

  // output clamps
  always_comb begin
    zeta_clip = opa[ACC_WIDTH-1:32] != '0;
    if (!zeta_clip) begin
      zeta_c = opa[31:0];
    end else begin
      zeta_c = opa[ACC_WIDTH-1] ? 32'h0000_0000 : 32'hffff_ffff;
    end
    zr_clip = !((&opa[ACC_WIDTH-1:31]) || !(|opa[ACC_WIDTH-1:31]));
    zi_clip = !((&opb[ACC_WIDTH-1:31]) || !(|opb[ACC_WIDTH-1:31]));
    zr_c = zr_clip ? (opa[ACC_WIDTH-1] ? 32'h8000_0000 : 32'h7fff_ffff) : opa[31:0];
    zi_c = zi_clip ? (opb[ACC_WIDTH-1] ? 32'h8000_0000 : 32'h7fff_ffff) : opb[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      sticky <= 1'b0;
      zdiv   <= 1'b0;
    end else begin
      if ((cmd.alu_wr && alu_ovf) || (mul_done && mul_sat) || (div_done && div_sat) ||
          (cmd.latch_zeta && zeta_clip)) begin
        sticky <= 1'b1;
      end
      if (cmd.set_zdiv) begin
        zdiv <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_zeta) begin
      zeta_hold <= zeta_c;
    end
    if (cmd.emit) begin
      zeta_out     <= zeta_hold;
      z_re         <= zr_c;
      z_im         <= zi_c;
      saturated    <= sticky | zr_clip | zi_clip;
      zero_divisor <= zdiv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.unit_done = mul_done | div_done;
    sts.opb_zero  = opb == '0;
    sts.out_free  = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

// File: rtl/amp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "amp_residual_and_variance_macros.svh"
module amp_ctrl
  import amp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic op,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0]      state, state_next;
  logic [PC_W-1:0] pc, pc_next;

  always_comb begin
    cmd            = '0;
    cmd.ins        = prog(pc);
    state_next     = state;
    pc_next        = pc;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          pc_next    = op ? FIN_PC : '0;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (cmd.ins.kind)
          K_MUL: begin
            cmd.mul_start = 1'b1;
            state_next    = S_WAIT;
          end
          K_DIV: begin
            cmd.div_start = 1'b1;
            state_next    = S_WAIT;
          end
          K_ADD, K_SUB: begin
            cmd.alu_wr = 1'b1;
            pc_next    = pc + 1'b1;
            state_next = S_READ;
          end
          K_BZ: begin
            // zero divisor: flag it and skip the whole term
            if (sts.opb_zero) begin
              cmd.set_zdiv = 1'b1;
              pc_next      = cmd.ins.tgt;
            end else begin
              pc_next = pc + 1'b1;
            end
            state_next = S_READ;
          end
          K_OUTZ: begin
            cmd.latch_zeta = 1'b1;
            pc_next        = pc + 1'b1;
            state_next     = S_READ;
          end
          K_OUT: begin
            if (sts.out_free) begin
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      default: begin
        if (sts.unit_done) begin
          pc_next    = pc + 1'b1;
          state_next = S_READ;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  assign in_stall = rst || (state != S_IDLE);

  `ARV_ASSERT_NEXT(a_accept_fetch, (state == S_IDLE) && in_valid, state == S_READ, "no fetch")
  `ARV_ASSERT_NEXT(a_unit_wait, cmd.mul_start || cmd.div_start, state == S_WAIT, "no wait")
  `ARV_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free, "result emitted over an untaken one")
  `ARV_ASSERT_NOW(a_pc_range, state != S_IDLE, pc <= LAST_PC, "sequencer ran past program")

endmodule
`default_nettype wire

// File: rtl/amp_residual_and_variance.sv
`timescale 1ns / 1ps
`default_nettype none
// Bilinear AMP residual and residual variance for one (m,t) pair.
// Input channel: in_valid / in_stall, one transfer per item. op = 0 items add
// one element to the running sums and give no result; op = 1 items carry y,
// Z_c, zeta_c, Z_d and zeta_d, produce one result and clear the sums.
// Output channel: out_valid / out_stall, one transfer per finish item.
// cfg_we / cfg_data write noise_variance; write it only while idle.
// Throughput: one item at a time. The time an item takes is set by the shared
// multiplier (four half-width partial products and a rounding step, 22
// products an element) and the bit-serial divider (one quotient bit a cycle,
// 80 bits, four divides in a finish); a zero divisor skips its term's
// products and divides.
// out_valid is registered from the output step and rises as the sequencer
// returns to idle, when the next item can be taken.
// Reset (rst, synchronous) clears the sums, flags and sequencer, holds in_stall
// high and sets noise_variance to 1.0. A result waits in the output register
// while out_stall is high; the next element item is still taken, and a finish
// item holds in its last step until the previous result has been taken.
module amp_residual_and_variance
  import amp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [30:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              op,
  input  wire logic signed [31:0] h_re,
  input  wire logic signed [31:0] h_im,
  input  wire logic [30:0]       vh,
  input  wire logic signed [31:0] x_re,
  input  wire logic signed [31:0] x_im,
  input  wire logic [30:0]       vx,
  input  wire logic signed [31:0] xp_re,
  input  wire logic signed [31:0] xp_im,
  input  wire logic signed [31:0] hp_re,
  input  wire logic signed [31:0] hp_im,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            zeta_out,
  output logic signed [31:0]     z_re,
  output logic signed [31:0]     z_im,
  output logic                   saturated,
  output logic                   zero_divisor
);

  cmd_t cmd;
  sts_t sts;

  amp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .cmd      (cmd),
    .sts      (sts)
  );

  amp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .h_re         (h_re),
    .h_im         (h_im),
    .vh           (vh),
    .x_re         (x_re),
    .x_im         (x_im),
    .vx           (vx),
    .xp_re        (xp_re),
    .xp_im        (xp_im),
    .hp_re        (hp_re),
    .hp_im        (hp_im),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .zeta_out     (zeta_out),
    .z_re         (z_re),
    .z_im         (z_im),
    .saturated    (saturated),
    .zero_divisor (zero_divisor)
  );

endmodule
`default_nettype wire
